>>> src/rac_pkg.sv
// Package for the reachability closure counter: sizes, field widths and the
// control bundle that the sequencer sends to the row of matrix cells.
// No dependencies.
package rac_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int NC_W      = $clog2(MAX_NODES + 1);

    localparam int NODE_FIELD_W  = 6;
    localparam int COUNT_FIELD_W = 7;

    localparam logic [COUNT_FIELD_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    typedef struct packed {
        logic             load;
        logic             rotate;
        logic             close_en;
        logic             edge_we;
        logic [IDX_W-1:0] step;
        logic [NC_W-1:0]  nc_eff;
        logic [IDX_W-1:0] edge_src;
        logic [IDX_W-1:0] edge_tgt;
    } cell_ctrl_t;

endpackage

>>> src/rac_cell.sv
// One matrix cell: keeps one adjacency row and one working closure row.
// Depends on rac_pkg.
module rac_cell
    import rac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     cell_index,
    input  cell_ctrl_t           ctrl,
    input  logic [MAX_NODES-1:0] pivot_row,
    input  logic [MAX_NODES-1:0] next_row_in,
    input  logic [IDX_W-1:0]     next_tag_in,
    output logic [MAX_NODES-1:0] row_out,
    output logic [IDX_W-1:0]     tag_out,
    output logic [MAX_NODES-1:0] clos_row,
    output logic                 ok
);

    logic [MAX_NODES-1:0] adj_reg;
    logic [MAX_NODES-1:0] clos_reg;
    logic [IDX_W-1:0]     tag_reg;
    logic                 hit;

    // A row absorbs the pivot row when it already reaches the pivot node.
    assign hit      = ctrl.close_en & clos_reg[ctrl.step];
    assign row_out  = hit ? (clos_reg | pivot_row) : clos_reg;
    assign tag_out  = tag_reg;
    assign clos_row = clos_reg;

    // Node tag_reg is linked to the pivot node in one direction or the other, or lies outside the nodes in use.
    assign ok = (32'(tag_reg) >= 32'(ctrl.nc_eff)) | clos_reg[ctrl.step]
              | pivot_row[tag_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg <= '0;
        end
        else if (ctrl.edge_we && (ctrl.edge_src == cell_index))
        begin
            adj_reg[ctrl.edge_tgt] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            clos_reg <= adj_reg | (MAX_NODES'(1) << cell_index);
            tag_reg  <= cell_index;
        end
        else if (ctrl.rotate)
        begin
            clos_reg <= next_row_in;
            tag_reg  <= next_tag_in;
        end
    end

endmodule

>>> src/rac_chain.sv
// Ring of matrix cells; while rotation is enabled, rows rotate one cell per cycle so the pivot row
// always sits in cell zero. Depends on rac_pkg and rac_cell.
module rac_chain
    import rac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    output logic       all_ok
);

    logic [MAX_NODES-1:0] row_out  [MAX_NODES];
    logic [IDX_W-1:0]     tag_out  [MAX_NODES];
    logic [MAX_NODES-1:0] clos_row [MAX_NODES];
    logic [MAX_NODES-1:0] ok_vec;

    for (genvar c = 0; c < MAX_NODES; c++)
    begin : g_cell
        rac_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_index  (IDX_W'(c)),
            .ctrl        (ctrl),
            .pivot_row   (clos_row[0]),
            .next_row_in (row_out[(c + 1) % MAX_NODES]),
            .next_tag_in (tag_out[(c + 1) % MAX_NODES]),
            .row_out     (row_out[c]),
            .tag_out     (tag_out[c]),
            .clos_row    (clos_row[c]),
            .ok          (ok_vec[c])
        );
    end

    assign all_ok = &ok_vec;

endmodule

>>> src/reachability_closure_counter_unit.sv
// An evaluate request passes through a load of the closure rows, MAX_NODES closure
// rounds, MAX_NODES count steps and an output step that registers the result. Edge
// requests are taken one per cycle while the unit is idle; after an evaluate no
// request is taken until its result is registered, and none while a finished count
// waits behind a stalled result. Reset clears the adjacency matrix
// and sets node_count to 64. Depends on rac_pkg, rac_chain and rac_cell.
module reachability_closure_counter_unit
    import rac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [COUNT_FIELD_W-1:0] cfg_data,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     operation,
    input  logic [NODE_FIELD_W-1:0]  edge_source,
    input  logic [NODE_FIELD_W-1:0]  edge_target,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [COUNT_FIELD_W-1:0] known_count
);

    // The sequencer walks through a load of the closure rows, one Warshall
    // round per cycle with the pivot row rotated into cell zero, and then one
    // count step per cycle in which the pivot node is tested against every row.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLOSE,
        ST_COUNT,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic [NC_W-1:0]          count_reg, count_next;
    logic                     res_valid_reg, res_valid_next;
    logic [COUNT_FIELD_W-1:0] known_count_reg, known_count_next;
    logic [COUNT_FIELD_W-1:0] node_count_reg, node_count_next;

    logic            req_accept;
    logic            res_free;
    logic            step_last;
    logic            step_in_use;
    logic [NC_W-1:0] nc_eff;
    logic            edge_in_range;
    logic            all_ok;
    cell_ctrl_t      ctrl;

    // A node count above the matrix size saturates to the matrix size.
    assign nc_eff = (32'(node_count_reg) > MAX_NODES) ? NC_W'(MAX_NODES)
                                                     : NC_W'(node_count_reg);

    assign req_stall   = (state_reg != ST_IDLE);
    assign req_accept  = req_valid && !req_stall;
    assign res_free    = !res_valid_reg || !res_stall;
    assign step_last   = (step_reg == IDX_W'(MAX_NODES - 1));
    assign step_in_use = (32'(step_reg) < 32'(nc_eff));

    // Edges that touch a node outside the nodes in use are dropped.
    assign edge_in_range = (32'(edge_source) < 32'(nc_eff))
                        && (32'(edge_target) < 32'(nc_eff));

    always_comb
    begin
        ctrl          = '0;
        ctrl.load     = (state_reg == ST_LOAD);
        ctrl.rotate   = (state_reg == ST_CLOSE) || (state_reg == ST_COUNT);
        ctrl.close_en = (state_reg == ST_CLOSE) && step_in_use;
        ctrl.edge_we  = req_accept && (operation == OP_ADD_EDGE) && edge_in_range;
        ctrl.step     = step_reg;
        ctrl.nc_eff   = nc_eff;
        ctrl.edge_src = IDX_W'(edge_source);
        ctrl.edge_tgt = IDX_W'(edge_target);
    end

    rac_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .all_ok (all_ok)
    );

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        count_next       = count_reg;
        known_count_next = known_count_reg;
        res_valid_next   = res_valid_reg && res_stall;
        node_count_next  = cfg_write ? cfg_data : node_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (operation == OP_EVALUATE))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                step_next  = '0;
                count_next = '0;
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    step_next  = '0;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (step_in_use && all_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the finished count until the result slot is free.
                if (res_free)
                begin
                    res_valid_next   = 1'b1;
                    known_count_next = COUNT_FIELD_W'(count_reg);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
            node_count_reg <= node_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        known_count_reg <= known_count_next;
    end

    assign res_valid   = res_valid_reg;
    assign known_count = known_count_reg;

`ifndef NO_ASSERTIONS
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without a finished count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> 32'(known_count_reg) <= MAX_NODES)
        else $error("count exceeds the number of nodes");

    a_close_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> (state_reg == ST_CLOSE) && (step_reg == '0))
        else $error("closure rounds did not start at the first pivot");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE || state_reg == ST_COUNT) |-> !ctrl.edge_we)
        else $error("edge written while the closure is being formed");
`endif

endmodule
